>>> rtl/rmt_pkg.sv
// Shared types and constants of the two-dimensional range-minimum tree.
package rmt_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'd1;
    localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = 6'd32;

    localparam int COORD_W = 6;
    localparam int VALUE_W = 32;

    localparam logic signed [VALUE_W-1:0] EMPTY_MIN = 32'sd1000000007;
    localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7fffffff;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RR_RD,
        S_RR_WR,
        S_RC_RD,
        S_RC_WR,
        S_BR_RD,
        S_BR_CHK,
        S_BC_RD,
        S_BC_CHK,
        S_B_RDA,
        S_B_RDB,
        S_B_LEAF,
        S_B_MIN,
        S_QR_RD,
        S_QR_CHK,
        S_QC_RD,
        S_QC_CHK,
        S_Q_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_tab_ctl;

    typedef struct packed {
        logic cell_we;
        logic cell_re;
        logic tree_we;
        logic tree_re;
    } t_store_ctl;

endpackage

>>> rtl/rmt_cmd_if.sv
// Command channel: one item per write, build or query command.
interface rmt_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      cmd;
    logic [rmt_pkg::COORD_W-1:0]     row_low;
    logic [rmt_pkg::COORD_W-1:0]     row_high;
    logic [rmt_pkg::COORD_W-1:0]     col_low;
    logic [rmt_pkg::COORD_W-1:0]     col_high;
    logic signed [rmt_pkg::VALUE_W-1:0] cell_value;

    modport source (
        output valid, cmd, row_low, row_high, col_low, col_high, cell_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, row_low, row_high, col_low, col_high, cell_value,
        output ready
    );
endinterface

>>> rtl/rmt_res_if.sv
// Result channel: one item per query.
interface rmt_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [rmt_pkg::VALUE_W-1:0] min_value;

    modport source (output valid, min_value, input ready);
    modport sink   (input valid, min_value, output ready);
endinterface

>>> rtl/rmt_info_table.sv
// Node range table of one tree dimension, with coverage tests against a query range.
module rmt_info_table #(
    parameter int AW = 7,
    parameter int KW = 6
) (
    input  logic              i_clk,
    input  rmt_pkg::t_tab_ctl i_ctl,
    input  logic [AW-1:0]     i_waddr,
    input  logic [AW-1:0]     i_raddr,
    input  logic [KW-1:0]     i_wlo,
    input  logic [KW-1:0]     i_whi,
    input  logic [KW-1:0]     i_wplo,
    input  logic [KW-1:0]     i_wphi,
    input  logic              i_wvalid,
    input  logic [KW-1:0]     i_qlo,
    input  logic [KW-1:0]     i_qhi,
    output logic [KW-1:0]     o_lo,
    output logic [KW-1:0]     o_hi,
    output logic              o_valid,
    output logic              o_leaf,
    output logic              o_cov,
    output logic              o_pcov
);
    import rmt_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [KW-1:0] r_mem_lo  [DEPTH];
    logic [KW-1:0] r_mem_hi  [DEPTH];
    logic [KW-1:0] r_mem_plo [DEPTH];
    logic [KW-1:0] r_mem_phi [DEPTH];
    logic          r_mem_vld [DEPTH];

    logic [KW-1:0] r_plo;
    logic [KW-1:0] r_phi;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem_lo[i_waddr]  <= i_wlo;
            r_mem_hi[i_waddr]  <= i_whi;
            r_mem_plo[i_waddr] <= i_wplo;
            r_mem_phi[i_waddr] <= i_wphi;
            r_mem_vld[i_waddr] <= i_wvalid;
        end
        if (i_ctl.re) begin
            o_lo    <= r_mem_lo[i_raddr];
            o_hi    <= r_mem_hi[i_raddr];
            r_plo   <= r_mem_plo[i_raddr];
            r_phi   <= r_mem_phi[i_raddr];
            o_valid <= r_mem_vld[i_raddr];
        end
    end

    assign o_leaf = (o_lo == o_hi);
    assign o_cov  = (o_lo >= i_qlo) && (o_hi <= i_qhi);
    assign o_pcov = (r_plo >= i_qlo) && (r_phi <= i_qhi);

endmodule

>>> rtl/rmt_grid_store.sv
// Cell memory and tree node memory, each with one write and one registered read port.
module rmt_grid_store #(
    parameter int RAW = 7,
    parameter int CAW = 7,
    parameter int CRW = 5,
    parameter int CCW = 5
) (
    input  logic                              i_clk,
    input  rmt_pkg::t_store_ctl               i_ctl,
    input  logic [CRW+CCW-1:0]                i_cell_waddr,
    input  logic signed [rmt_pkg::VALUE_W-1:0] i_cell_wdata,
    input  logic [CRW+CCW-1:0]                i_cell_raddr,
    output logic signed [rmt_pkg::VALUE_W-1:0] o_cell_rdata,
    input  logic [RAW+CAW-1:0]                i_tree_waddr,
    input  logic signed [rmt_pkg::VALUE_W-1:0] i_tree_wdata,
    input  logic [RAW+CAW-1:0]                i_tree_raddr,
    output logic signed [rmt_pkg::VALUE_W-1:0] o_tree_rdata
);
    import rmt_pkg::*;

    localparam int CELL_DEPTH = 1 << (CRW + CCW);
    localparam int TREE_DEPTH = 1 << (RAW + CAW);

    logic signed [VALUE_W-1:0] r_cell_mem [CELL_DEPTH];
    logic signed [VALUE_W-1:0] r_tree_mem [TREE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.cell_we) begin
            r_cell_mem[i_cell_waddr] <= i_cell_wdata;
        end
        if (i_ctl.cell_re) begin
            o_cell_rdata <= r_cell_mem[i_cell_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tree_we) begin
            r_tree_mem[i_tree_waddr] <= i_tree_wdata;
        end
        if (i_ctl.tree_re) begin
            o_tree_rdata <= r_tree_mem[i_tree_raddr];
        end
    end

endmodule

>>> rtl/range_min_2d_tree.sv
// Top level: two-dimensional segment tree for rectangle minimum queries.
//
// Use: items arrive on i_cmd (valid/ready). A write item stores one cell at
// a 1-based row and column; the block stays ready. A build item first walks
// the row and column node tables (one read and one write per node in each
// dimension), then visits every row node from the highest index down, and
// inside each valid one every column node from the highest index down. A
// query first repeats the table walk if none has run since reset or since
// the last count write, then scans row nodes and, for each row node that
// lies in the rectangle but whose parent does not, scans the column nodes;
// the one shared compare unit folds each chosen node into the running
// minimum. The result item appears on o_res in the cycle after the scan
// ends. The node memory has a single read port. The block takes no new
// item until the current one is done, including while the result waits on
// o_res; a stalled receiver simply holds it. Reset sets both count
// registers to 32 and returns to idle; the memories hold nothing defined
// until written. Configuration writes on i_cfg_* take effect at the next
// build or query.
module range_min_2d_tree #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rmt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rmt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rmt_cmd_if.sink                           i_cmd,
    rmt_res_if.source                         o_res
);
    import rmt_pkg::*;

    localparam int RDEP = 4 * MAX_ROWS;
    localparam int CDEP = 4 * MAX_COLS;
    localparam int RAW  = $clog2(RDEP);
    localparam int CAW  = $clog2(CDEP);
    localparam int CRW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW0  = ($clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1)) ?
                          $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
    localparam int KW   = (KW0 > COORD_W) ? KW0 : COORD_W;

    // configuration
    logic [CFG_DATA_W-1:0] r_rows_used;
    logic [CFG_DATA_W-1:0] r_cols_used;
    logic [KW-1:0]         eff_rows;
    logic [KW-1:0]         eff_cols;
    logic                  r_tab_stale;

    // sequencer and datapath registers
    t_state                    r_state, n_state;
    logic [RAW-1:0]            r_rn, n_rn;
    logic [CAW-1:0]            r_cn, n_cn;
    logic signed [VALUE_W-1:0] r_acc, n_acc;
    logic [KW-1:0]             r_qrlo, r_qrhi, r_qclo, r_qchi;
    logic                      r_is_query;

    // node tables
    t_tab_ctl       row_ctl, col_ctl;
    logic [RAW-1:0] row_raddr;
    logic [CAW-1:0] col_raddr;
    logic [KW-1:0]  row_lo, row_hi, col_lo, col_hi;
    logic           row_valid, row_leaf, row_cov, row_pcov;
    logic           col_valid, col_leaf, col_cov, col_pcov;
    logic [KW-1:0]  row_mid, col_mid;
    logic [KW-1:0]  row_wlo, row_whi, col_wlo, col_whi;
    logic           row_wvalid, col_wvalid;

    // grid store
    t_store_ctl                st_ctl;
    logic [CRW+CCW-1:0]        cell_waddr, cell_raddr;
    logic [RAW+CAW-1:0]        tree_waddr, tree_raddr;
    logic signed [VALUE_W-1:0] cell_rdata, tree_rdata, tree_wdata;

    logic                      cmd_accept;
    logic                      cell_in_range;
    logic                      root_full;
    logic                      canon_row, canon_col;
    logic                      bld_row_last, bld_col_last, q_row_last, q_col_last;
    logic signed [VALUE_W-1:0] min_val;

    // ---------------------------------------------------------------------
    // Configuration registers and effective counts (zero acts as one,
    // anything above the grid saturates to the grid size). Mark the node
    // tables out of date on any count write; clear the mark once a table
    // walk has finished.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= CFG_COUNT_RESET;
            r_cols_used <= CFG_COUNT_RESET;
            r_tab_stale <= 1'b1;
        end else if (i_cfg_we) begin
            r_tab_stale <= 1'b1;
            case (i_cfg_idx)
                CFG_ROWS_USED: r_rows_used <= i_cfg_data;
                CFG_COLS_USED: r_cols_used <= i_cfg_data;
                default: ;
            endcase
        end else if (r_state == S_RC_WR && q_col_last) begin
            r_tab_stale <= 1'b0;
        end
    end

    always_comb begin
        if (r_rows_used == '0) begin
            eff_rows = KW'(1);
        end else if (KW'(r_rows_used) > KW'(MAX_ROWS)) begin
            eff_rows = KW'(MAX_ROWS);
        end else begin
            eff_rows = KW'(r_rows_used);
        end
        if (r_cols_used == '0) begin
            eff_cols = KW'(1);
        end else if (KW'(r_cols_used) > KW'(MAX_COLS)) begin
            eff_cols = KW'(MAX_COLS);
        end else begin
            eff_cols = KW'(r_cols_used);
        end
    end

    // ---------------------------------------------------------------------
    // Common decode
    // ---------------------------------------------------------------------
    assign cmd_accept    = i_cmd.valid && i_cmd.ready;
    assign cell_in_range = (i_cmd.row_low != '0) && (KW'(i_cmd.row_low) <= KW'(MAX_ROWS)) &&
                           (i_cmd.col_low != '0) && (KW'(i_cmd.col_low) <= KW'(MAX_COLS));
    // a rectangle that covers both roots reads the root node alone,
    // otherwise some branch of the walk falls outside and adds the sentinel
    assign root_full     = (KW'(i_cmd.row_low) <= KW'(1)) && (eff_rows <= KW'(i_cmd.row_high)) &&
                           (KW'(i_cmd.col_low) <= KW'(1)) && (eff_cols <= KW'(i_cmd.col_high));

    assign canon_row = row_valid && row_cov && ((r_rn == RAW'(1)) || !row_pcov);
    assign canon_col = col_valid && col_cov && ((r_cn == CAW'(1)) || !col_pcov);

    assign bld_row_last = (r_rn == RAW'(1));
    assign bld_col_last = (r_cn == CAW'(1));
    assign q_row_last   = (r_rn == RAW'(RDEP - 1));
    assign q_col_last   = (r_cn == CAW'(CDEP - 1));

    // shared compare unit
    assign min_val = (tree_rdata < r_acc) ? tree_rdata : r_acc;

    // ---------------------------------------------------------------------
    // Child ranges for the table pass: derive node n from its parent n/2.
    // ---------------------------------------------------------------------
    assign row_mid = KW'(({1'b0, row_lo} + {1'b0, row_hi}) >> 1);
    assign col_mid = KW'(({1'b0, col_lo} + {1'b0, col_hi}) >> 1);

    always_comb begin
        if (r_rn == RAW'(1)) begin
            row_wlo    = KW'(1);
            row_whi    = eff_rows;
            row_wvalid = 1'b1;
        end else begin
            row_wlo    = r_rn[0] ? row_mid + KW'(1) : row_lo;
            row_whi    = r_rn[0] ? row_hi : row_mid;
            row_wvalid = row_valid && !row_leaf;
        end
        if (r_cn == CAW'(1)) begin
            col_wlo    = KW'(1);
            col_whi    = eff_cols;
            col_wvalid = 1'b1;
        end else begin
            col_wlo    = r_cn[0] ? col_mid + KW'(1) : col_lo;
            col_whi    = r_cn[0] ? col_hi : col_mid;
            col_wvalid = col_valid && !col_leaf;
        end
    end

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_accept) begin
                    case (i_cmd.cmd)
                        CMD_BUILD: n_state = S_RR_RD;
                        CMD_QUERY: n_state = r_tab_stale ? S_RR_RD : S_QR_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RR_RD:  n_state = S_RR_WR;
            S_RR_WR:  n_state = q_row_last ? S_RC_RD : S_RR_RD;
            S_RC_RD:  n_state = S_RC_WR;
            S_RC_WR: begin
                if (!q_col_last) begin
                    n_state = S_RC_RD;
                end else begin
                    n_state = r_is_query ? S_QR_RD : S_BR_RD;
                end
            end
            S_BR_RD:  n_state = S_BR_CHK;
            S_BR_CHK: begin
                if (row_valid) begin
                    n_state = S_BC_RD;
                end else begin
                    n_state = bld_row_last ? S_IDLE : S_BR_RD;
                end
            end
            S_BC_RD:  n_state = S_BC_CHK;
            S_BC_CHK: begin
                if (col_valid) begin
                    n_state = S_B_RDA;
                end else if (!bld_col_last) begin
                    n_state = S_BC_RD;
                end else begin
                    n_state = bld_row_last ? S_IDLE : S_BR_RD;
                end
            end
            S_B_RDA:  n_state = (row_leaf && col_leaf) ? S_B_LEAF : S_B_RDB;
            S_B_RDB:  n_state = S_B_MIN;
            S_B_LEAF, S_B_MIN: begin
                if (!bld_col_last) begin
                    n_state = S_BC_RD;
                end else begin
                    n_state = bld_row_last ? S_IDLE : S_BR_RD;
                end
            end
            S_QR_RD:  n_state = S_QR_CHK;
            S_QR_CHK: begin
                if (canon_row) begin
                    n_state = S_QC_RD;
                end else begin
                    n_state = q_row_last ? S_OUT : S_QR_RD;
                end
            end
            S_QC_RD:  n_state = S_QC_CHK;
            S_QC_CHK: begin
                if (canon_col) begin
                    n_state = S_Q_ACC;
                end else if (!q_col_last) begin
                    n_state = S_QC_RD;
                end else begin
                    n_state = q_row_last ? S_OUT : S_QR_RD;
                end
            end
            S_Q_ACC: begin
                if (!q_col_last) begin
                    n_state = S_QC_RD;
                end else begin
                    n_state = q_row_last ? S_OUT : S_QR_RD;
                end
            end
            S_OUT:    n_state = o_res.ready ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Outputs: memory controls and handshake
    // ---------------------------------------------------------------------
    always_comb begin
        row_ctl    = '0;
        col_ctl    = '0;
        st_ctl     = '0;
        row_raddr  = r_rn;
        col_raddr  = r_cn;
        tree_raddr = {r_rn, r_cn};
        tree_wdata = min_val;
        case (r_state)
            S_IDLE: begin
                st_ctl.cell_we = cmd_accept && (i_cmd.cmd == CMD_WRITE) && cell_in_range;
            end
            S_RR_RD: begin
                row_ctl.re = 1'b1;
                row_raddr  = r_rn >> 1;
            end
            S_RR_WR: row_ctl.we = 1'b1;
            S_RC_RD: begin
                col_ctl.re = 1'b1;
                col_raddr  = r_cn >> 1;
            end
            S_RC_WR: col_ctl.we = 1'b1;
            S_BR_RD, S_QR_RD: row_ctl.re = 1'b1;
            S_BC_RD, S_QC_RD: col_ctl.re = 1'b1;
            S_B_RDA: begin
                st_ctl.cell_re = row_leaf && col_leaf;
                st_ctl.tree_re = !(row_leaf && col_leaf);
                tree_raddr     = col_leaf ? {r_rn[RAW-2:0], 1'b0, r_cn}
                                          : {r_rn, r_cn[CAW-2:0], 1'b0};
            end
            S_B_RDB: begin
                st_ctl.tree_re = 1'b1;
                tree_raddr     = col_leaf ? {r_rn[RAW-2:0], 1'b1, r_cn}
                                          : {r_rn, r_cn[CAW-2:0], 1'b1};
            end
            S_B_LEAF: begin
                st_ctl.tree_we = 1'b1;
                tree_wdata     = cell_rdata;
            end
            S_B_MIN:  st_ctl.tree_we = 1'b1;
            S_QC_CHK: st_ctl.tree_re = canon_col;
            default: ;
        endcase
    end

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_res.valid     = (r_state == S_OUT);
    assign o_res.min_value = r_acc;

    assign cell_waddr = {CRW'(i_cmd.row_low - COORD_W'(1)), CCW'(i_cmd.col_low - COORD_W'(1))};
    assign cell_raddr = {CRW'(row_lo - KW'(1)), CCW'(col_lo - KW'(1))};
    assign tree_waddr = {r_rn, r_cn};

    // ---------------------------------------------------------------------
    // Datapath: node counters and running minimum
    // ---------------------------------------------------------------------
    always_comb begin
        n_rn  = r_rn;
        n_cn  = r_cn;
        n_acc = r_acc;
        case (r_state)
            S_IDLE: begin
                n_rn  = RAW'(1);
                n_cn  = CAW'(1);
                n_acc = root_full ? MAX_VALUE : EMPTY_MIN;
            end
            S_RR_WR: if (!q_row_last) n_rn = r_rn + RAW'(1);
            S_RC_WR: begin
                if (!q_col_last) begin
                    n_cn = r_cn + CAW'(1);
                end else if (r_is_query) begin
                    // restart both counters at the roots for the query scan
                    n_rn = RAW'(1);
                    n_cn = CAW'(1);
                end
            end
            S_BR_CHK: begin
                if (row_valid) begin
                    n_cn = CAW'(CDEP - 1);
                end else if (!bld_row_last) begin
                    n_rn = r_rn - RAW'(1);
                end
            end
            S_BC_CHK, S_B_LEAF, S_B_MIN: begin
                if (r_state == S_B_MIN || r_state == S_B_LEAF || !col_valid) begin
                    if (!bld_col_last) begin
                        n_cn = r_cn - CAW'(1);
                    end else if (!bld_row_last) begin
                        n_rn = r_rn - RAW'(1);
                    end
                end
            end
            S_B_RDB: n_acc = tree_rdata;
            S_QR_CHK: begin
                if (canon_row) begin
                    n_cn = CAW'(1);
                end else if (!q_row_last) begin
                    n_rn = r_rn + RAW'(1);
                end
            end
            S_QC_CHK, S_Q_ACC: begin
                if (r_state == S_Q_ACC) begin
                    n_acc = min_val;
                end
                if (r_state == S_Q_ACC || !canon_col) begin
                    if (!q_col_last) begin
                        n_cn = r_cn + CAW'(1);
                    end else if (!q_row_last) begin
                        n_rn = r_rn + RAW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the query rectangle for the whole walk
    always_ff @(posedge i_clk) begin
        r_rn  <= n_rn;
        r_cn  <= n_cn;
        r_acc <= n_acc;
        if (cmd_accept) begin
            r_qrlo     <= KW'(i_cmd.row_low);
            r_qrhi     <= KW'(i_cmd.row_high);
            r_qclo     <= KW'(i_cmd.col_low);
            r_qchi     <= KW'(i_cmd.col_high);
            r_is_query <= (i_cmd.cmd == CMD_QUERY);
        end
    end

    // ---------------------------------------------------------------------
    // Storage
    // ---------------------------------------------------------------------
    rmt_info_table #(.AW(RAW), .KW(KW)) u_row_table (
        .i_clk    (i_clk),
        .i_ctl    (row_ctl),
        .i_waddr  (r_rn),
        .i_raddr  (row_raddr),
        .i_wlo    (row_wlo),
        .i_whi    (row_whi),
        .i_wplo   (row_lo),
        .i_wphi   (row_hi),
        .i_wvalid (row_wvalid),
        .i_qlo    (r_qrlo),
        .i_qhi    (r_qrhi),
        .o_lo     (row_lo),
        .o_hi     (row_hi),
        .o_valid  (row_valid),
        .o_leaf   (row_leaf),
        .o_cov    (row_cov),
        .o_pcov   (row_pcov)
    );

    rmt_info_table #(.AW(CAW), .KW(KW)) u_col_table (
        .i_clk    (i_clk),
        .i_ctl    (col_ctl),
        .i_waddr  (r_cn),
        .i_raddr  (col_raddr),
        .i_wlo    (col_wlo),
        .i_whi    (col_whi),
        .i_wplo   (col_lo),
        .i_wphi   (col_hi),
        .i_wvalid (col_wvalid),
        .i_qlo    (r_qclo),
        .i_qhi    (r_qchi),
        .o_lo     (col_lo),
        .o_hi     (col_hi),
        .o_valid  (col_valid),
        .o_leaf   (col_leaf),
        .o_cov    (col_cov),
        .o_pcov   (col_pcov)
    );

    rmt_grid_store #(.RAW(RAW), .CAW(CAW), .CRW(CRW), .CCW(CCW)) u_store (
        .i_clk        (i_clk),
        .i_ctl        (st_ctl),
        .i_cell_waddr (cell_waddr),
        .i_cell_wdata (i_cmd.cell_value),
        .i_cell_raddr (cell_raddr),
        .o_cell_rdata (cell_rdata),
        .i_tree_waddr (tree_waddr),
        .i_tree_wdata (tree_wdata),
        .i_tree_raddr (tree_raddr),
        .o_tree_rdata (tree_rdata)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> ($past(r_state) == S_QR_CHK || $past(r_state) == S_QC_CHK ||
                                $past(r_state) == S_Q_ACC))
        else $error("result raised outside the end of a query scan");

    a_node_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BR_RD || r_state == S_QR_RD || r_state == S_BC_RD ||
         r_state == S_QC_RD) |-> (r_rn != '0 && r_cn != '0))
        else $error("tree walk reached node index zero");

    a_write_keeps_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_accept && i_cmd.cmd == CMD_WRITE) |=> i_cmd.ready)
        else $error("cell write left the block busy");

    a_tree_write_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.tree_we |-> $past(r_state) == S_B_RDB || $past(r_state) == S_B_RDA)
        else $error("tree node written outside a build step");

endmodule
